/* hw/rtl/ptc_pkg.sv */
// ptc_pkg: shared types and constants for the pretrigger threshold capture block.
// Used by ptc_store and pretrigger_threshold_capture; depends on nothing.
`default_nettype none

package ptc_pkg;

  localparam int DEPTH      = 128;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int POS_W      = $clog2(DEPTH + 1);
  localparam int SAMPLE_W   = 12;
  localparam int THRESH_W   = 12;
  localparam int PRE_LEN_W  = 8;
  localparam int FUNC_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [THRESH_W-1:0]  THRESH_RESET  = 12'd2048;
  localparam logic [PRE_LEN_W-1:0] PRE_LEN_RESET = 8'd50;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_REARM  = 2'd2
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_PRE_LEN   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
  } store_req_t;

endpackage

`default_nettype wire

/* hw/rtl/pretrigger_threshold_capture.sv */
// pretrigger_threshold_capture: threshold-triggered sample capture with pretrigger ring.
// Depends on ptc_pkg and ptc_store.
//
//   channel  | signals                          | contents
//   s_*      | tvalid tready tdata tuser        | tuser func; tdata sample, read_index
//   m_*      | tvalid tready tdata              | read_data, status flags, ring_next
//   cfg_*    | we addr data                     | 0 threshold, 1 pretrigger_length
//
// One item per cycle sustained while m_tready stays high; each item's result passes
// through the store read port and stage 1, then the output register.
// Sample writes and reads share the single store; state updates in the accept cycle.
// rst is synchronous; the store itself is not cleared.
// m_tready low holds the output register and stage 1, then s_tready drops.
`default_nettype none

module pretrigger_threshold_capture
  import ptc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [11:0] sample, [18:12] read_index, rest zero
  input  logic [FUNC_W-1:0]     s_tuser,   // [1:0] func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] read_data, [12] is_triggered,
                                           // [13] is_done, [20:14] ring_next,
                                           // [21] ring_wrapped, rest zero
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [THRESH_W-1:0]  threshold;
  logic [PRE_LEN_W-1:0] pre_len;

  logic                 skip_first, skip_first_next;
  logic [ADDR_W-1:0]    ring_pos, ring_pos_next;
  logic                 ring_full, ring_full_next;
  logic                 trig_flag, trig_flag_next;
  logic [POS_W-1:0]     post_pos, post_pos_next;
  logic                 done_flag, done_flag_next;

  logic                 s1_valid;
  logic                 s1_is_read;
  logic                 s1_trig;
  logic                 s1_done;
  logic [ADDR_W-1:0]    s1_ring_pos;
  logic                 s1_full;
  logic                 out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  logic                 s_fire;
  logic                 s1_move;
  func_t                func;
  logic [SAMPLE_W-1:0]  sample;
  logic [ADDR_W-1:0]    read_index;
  logic [POS_W-1:0]     ring_len;
  logic [POS_W-1:0]     ring_last;
  store_req_t           req;
  logic [SAMPLE_W-1:0]  rd_data;

  assign func       = func_t'(s_tuser);
  assign sample     = s_tdata[SAMPLE_W-1:0];
  assign read_index = s_tdata[SAMPLE_W +: ADDR_W];

  assign s1_move  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_move;
  assign s_fire   = s_tvalid && s_tready;

  // effective ring length, clamped to 1..DEPTH
  always_comb begin
    if (pre_len == '0) begin
      ring_len = POS_W'(1);
    end else if (POS_W'(pre_len) > POS_W'(DEPTH)) begin
      ring_len = POS_W'(DEPTH);
    end else begin
      ring_len = POS_W'(pre_len);
    end
    ring_last = ring_len - POS_W'(1);
  end

  always_comb begin
    skip_first_next = skip_first;
    ring_pos_next   = ring_pos;
    ring_full_next  = ring_full;
    trig_flag_next  = trig_flag;
    post_pos_next   = post_pos;
    done_flag_next  = done_flag;
    req.wr_en       = 1'b0;
    req.wr_addr     = ring_pos;
    req.wr_data     = sample;
    req.rd_en       = 1'b0;
    req.rd_addr     = read_index;
    if (s_fire) begin
      case (func)
        FUNC_SAMPLE: begin
          if (skip_first) begin
            skip_first_next = 1'b0;
          end else if (!trig_flag) begin
            req.wr_en = 1'b1;
            if (POS_W'(ring_pos) >= ring_last) begin
              ring_pos_next  = '0;
              ring_full_next = 1'b1;
            end else begin
              ring_pos_next = ring_pos + ADDR_W'(1);
            end
            if (sample > threshold) begin
              trig_flag_next = 1'b1;
              post_pos_next  = ring_full_next ? ring_len : POS_W'(ring_pos_next);
            end
          end else if (post_pos < POS_W'(DEPTH)) begin
            req.wr_en     = 1'b1;
            req.wr_addr   = post_pos[ADDR_W-1:0];
            post_pos_next = post_pos + POS_W'(1);
          end else begin
            done_flag_next = 1'b1;
          end
        end
        FUNC_READ: begin
          req.rd_en = 1'b1;
        end
        FUNC_REARM: begin
          ring_pos_next  = '0;
          ring_full_next = 1'b0;
          trig_flag_next = 1'b0;
          post_pos_next  = '0;
          done_flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  ptc_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      pre_len   <= PRE_LEN_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
        REG_PRE_LEN:   pre_len   <= cfg_data[PRE_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_first <= 1'b1;
      ring_pos   <= '0;
      ring_full  <= 1'b0;
      trig_flag  <= 1'b0;
      post_pos   <= '0;
      done_flag  <= 1'b0;
    end else begin
      skip_first <= skip_first_next;
      ring_pos   <= ring_pos_next;
      ring_full  <= ring_full_next;
      trig_flag  <= trig_flag_next;
      post_pos   <= post_pos_next;
      done_flag  <= done_flag_next;
    end
  end

  // stage 1: waits for the store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_is_read  <= (func == FUNC_READ);
      s1_trig     <= trig_flag_next;
      s1_done     <= done_flag_next;
      s1_ring_pos <= ring_pos_next;
      s1_full     <= ring_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= {(OUT_DATA_W - SAMPLE_W - ADDR_W - 3)'(0), s1_full, s1_ring_pos,
                   s1_done, s1_trig, s1_is_read ? rd_data : SAMPLE_W'(0)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

`ifndef SYNTHESIS
  a_done_needs_trig: assert property (@(posedge clk) disable iff (rst)
    done_flag |-> trig_flag)
    else $error("done set without trigger");

  a_post_in_range: assert property (@(posedge clk) disable iff (rst)
    trig_flag |-> (post_pos <= POS_W'(DEPTH)))
    else $error("post-trigger position beyond store");

  a_rearm_clears: assert property (@(posedge clk) disable iff (rst)
    (s_fire && func == FUNC_REARM) |=> (!trig_flag && !done_flag && !ring_full))
    else $error("rearm did not clear capture state");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    !(req.wr_en && req.rd_en))
    else $error("store read and write in one cycle");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ptc_store.sv */
// ptc_store: sample store, one write and one registered read port per cycle.
// Depends on ptc_pkg for widths and the request struct.
`default_nettype none

module ptc_store
  import ptc_pkg::*;
(
  input  logic                clk,
  input  store_req_t          req,
  output logic [SAMPLE_W-1:0] rd_data
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

/* bench/pretrigger_threshold_capture_tb.sv */
// Self-checking bench for pretrigger_threshold_capture: a directed table, then random capture runs.
// Expected items come from a local state model of the ring and post-trigger store.
// Depends on ptc_pkg and the pretrigger_threshold_capture RTL.
`default_nettype none

module pretrigger_threshold_capture_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int N_PHASES = 10;
  localparam int PHASE_ITEMS = 155;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [1:0]          pad;
    logic                ring_wrapped;
    logic [ADDR_W-1:0]   ring_next;
    logic                is_done;
    logic                is_triggered;
    logic [SAMPLE_W-1:0] read_data;
  } capture_out_t;

  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [SAMPLE_W-1:0] smp;
    logic [ADDR_W-1:0]   idx;
    bit                  typed;
    capture_out_t        want;
  } table_row_t;

  typedef enum int {PLAN_PRE, PLAN_TRIG, PLAN_POST, PLAN_READ, PLAN_REARM} plan_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pretrigger_threshold_capture dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #5ns clk = ~clk;

  // capture model state
  logic [THRESH_W-1:0]  thr_q = THRESH_RESET;
  logic [PRE_LEN_W-1:0] prelen_q = PRE_LEN_RESET;
  logic [SAMPLE_W-1:0]  cap_store [DEPTH];
  bit                   written [DEPTH];
  int                   n_written = 0;
  logic [ADDR_W-1:0]    ring_pos = '0;
  logic                 ring_full = 1'b0;
  logic                 trig_flag = 1'b0;
  logic [POS_W-1:0]     post_pos = '0;
  logic                 done_flag = 1'b0;
  logic                 skip_first = 1'b1;

  capture_out_t pending_q[$];
  table_row_t   dir_rows[$];

  int  n_errors = 0;
  int  n_items = 0;
  int  n_reads = 0;
  int  n_trig = 0;
  int  n_done = 0;
  int  burst_left = 0;
  bit  sender_calm = 1'b0;
  bit  hold_req = 1'b0;
  plan_t plan_stage = PLAN_PRE;
  int  plan_left = 20;

  function automatic capture_out_t mk_out(int rd, bit trig, bit done, int rn, bit wrap);
    capture_out_t o;
    o = '0;
    o.read_data = SAMPLE_W'(rd);
    o.is_triggered = trig;
    o.is_done = done;
    o.ring_next = ADDR_W'(rn);
    o.ring_wrapped = wrap;
    return o;
  endfunction

  function automatic int ring_span();
    int n;
    n = prelen_q;
    if (n == 0) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  task automatic store_write(input int pos, input logic [SAMPLE_W-1:0] smp);
    cap_store[pos] = smp;
    if (!written[pos]) n_written++;
    written[pos] = 1'b1;
  endtask

  task automatic capture_step(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] smp,
                              input logic [ADDR_W-1:0] idx, output capture_out_t o);
    int span;
    logic [SAMPLE_W-1:0] rd;
    span = ring_span();
    rd = '0;
    case (f)
      FUNC_SAMPLE: begin
        if (skip_first) begin
          skip_first = 1'b0;
        end else if (!trig_flag) begin
          store_write(ring_pos, smp);
          if (int'(ring_pos) >= span - 1) begin
            ring_pos = '0;
            ring_full = 1'b1;
          end else begin
            ring_pos++;
          end
          if (smp > thr_q) begin
            trig_flag = 1'b1;
            post_pos = ring_full ? POS_W'(span) : POS_W'(ring_pos);
            n_trig++;
          end
        end else if (post_pos < DEPTH) begin
          store_write(post_pos, smp);
          post_pos++;
        end else begin
          if (!done_flag) n_done++;
          done_flag = 1'b1;
        end
      end
      FUNC_READ: begin
        rd = cap_store[idx];
        n_reads++;
      end
      FUNC_REARM: begin
        ring_pos = '0;
        ring_full = 1'b0;
        trig_flag = 1'b0;
        post_pos = '0;
        done_flag = 1'b0;
      end
      default: ;
    endcase
    o = mk_out(rd, trig_flag, done_flag, ring_pos, ring_full);
  endtask

  function automatic logic [ADDR_W-1:0] pick_written();
    int i;
    do i = $urandom_range(0, DEPTH - 1); while (!written[i]);
    return ADDR_W'(i);
  endfunction

  task automatic push_item(input logic [FUNC_W-1:0] f, input logic [SAMPLE_W-1:0] smp,
                           input logic [ADDR_W-1:0] idx, input bit typed,
                           input capture_out_t want);
    capture_out_t p;
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {{(IN_DATA_W - SAMPLE_W - ADDR_W){1'b0}}, idx, smp};
    do @(posedge clk); while (!s_tready);
    capture_step(f, smp, idx, p);
    pending_q.push_back(typed ? want : p);
    n_items++;
    if (hold_req || sender_calm) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 25) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  // well-formed capture runs with random content, plus some noise
  task automatic next_item(output logic [FUNC_W-1:0] f, output logic [SAMPLE_W-1:0] smp,
                           output logic [ADDR_W-1:0] idx);
    int t;
    t = thr_q;
    f = FUNC_SAMPLE;
    smp = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    idx = ADDR_W'($urandom_range(0, DEPTH - 1));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: f = FUNC_SAMPLE;
        1: if (n_written != 0) begin
          f = FUNC_READ;
          idx = pick_written();
        end
        2: f = FUNC_REARM;
        default: f = FUNC_UNUSED;
      endcase
      return;
    end
    case (plan_stage)
      PLAN_PRE: begin
        smp = SAMPLE_W'($urandom_range(0, t));
        if (plan_left > 1) begin
          plan_left--;
        end else begin
          plan_stage = (t == SAMPLE_MAX) ? PLAN_READ : PLAN_TRIG;
          plan_left = $urandom_range(2, 8);
        end
      end
      PLAN_TRIG: begin
        if (t < SAMPLE_MAX) smp = SAMPLE_W'($urandom_range(t + 1, SAMPLE_MAX));
        plan_stage = PLAN_POST;
        plan_left = $urandom_range(90, 135);
      end
      PLAN_POST: begin
        if (plan_left > 1) begin
          plan_left--;
        end else begin
          plan_stage = PLAN_READ;
          plan_left = $urandom_range(2, 8);
        end
      end
      PLAN_READ: begin
        if (n_written != 0) begin
          f = FUNC_READ;
          idx = pick_written();
        end
        if (plan_left > 1) plan_left--;
        else plan_stage = PLAN_REARM;
      end
      default: begin
        f = FUNC_REARM;
        plan_stage = PLAN_PRE;
        plan_left = $urandom_range(1, ring_span() + ring_span() / 2 + 2);
      end
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capture(input logic [THRESH_W-1:0] thr, input logic [PRE_LEN_W-1:0] len);
    cfg_we <= 1'b1;
    cfg_addr <= REG_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    cfg_addr <= REG_PRE_LEN;
    cfg_data <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_q = thr;
    prelen_q = len;
  endtask

  task automatic add_row(input logic [FUNC_W-1:0] f, input int smp, input int idx,
                         input bit typed, input capture_out_t want);
    table_row_t r;
    r.func = f;
    r.smp = SAMPLE_W'(smp);
    r.idx = ADDR_W'(idx);
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endtask

  task automatic report_bad(input string what, input capture_out_t want, input capture_out_t got);
    n_errors++;
    if (n_errors <= 10)
      $display({"%s: want rd=%0d trig=%0b done=%0b next=%0d wrap=%0b pad=%0b",
                " | got rd=%0d trig=%0b done=%0b next=%0d wrap=%0b pad=%0b"},
               what, want.read_data, want.is_triggered, want.is_done, want.ring_next,
               want.ring_wrapped, want.pad, got.read_data, got.is_triggered, got.is_done,
               got.ring_next, got.ring_wrapped, got.pad);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    capture_out_t seen, want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata;
      if (pending_q.size() == 0) begin
        report_bad("unexpected item", '0, seen);
      end else begin
        want = pending_q.pop_front();
        if (seen.read_data !== want.read_data || seen.is_triggered !== want.is_triggered ||
            seen.is_done !== want.is_done || seen.ring_next !== want.ring_next ||
            seen.ring_wrapped !== want.ring_wrapped || seen.pad !== want.pad)
          report_bad("mismatch", want, seen);
      end
    end
  end

  // receiver: changing stall pattern, plus a long hold-off on request
  int rx_cyc = 0;
  int rx_mode = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    rx_cyc++;
    if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_req) begin
      m_tready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) begin
        hold_cnt = 0;
        hold_req = 1'b0;
      end
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (rx_cyc % 4 != 3);
      endcase
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [FUNC_W-1:0]   f;
    logic [SAMPLE_W-1:0] smp;
    logic [ADDR_W-1:0]   idx;
    int thr_set [N_PHASES];
    int len_set [N_PHASES];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows at reset settings: threshold 2048, ring of 50
    add_row(FUNC_SAMPLE, SAMPLE_MAX, 127, 1, mk_out(0, 0, 0, 0, 0));  // dropped
    add_row(FUNC_SAMPLE, 0, 0, 1, mk_out(0, 0, 0, 1, 0));
    add_row(FUNC_READ, 0, 0, 1, mk_out(0, 0, 0, 1, 0));
    add_row(FUNC_SAMPLE, 2048, 0, 1, mk_out(0, 0, 0, 2, 0));           // equal, no trigger
    add_row(FUNC_SAMPLE, 2049, 0, 1, mk_out(0, 1, 0, 3, 0));
    add_row(FUNC_READ, 0, 2, 1, mk_out(2049, 1, 0, 3, 0));
    add_row(FUNC_SAMPLE, SAMPLE_MAX, 0, 1, mk_out(0, 1, 0, 3, 0));
    add_row(FUNC_READ, 0, 3, 1, mk_out(SAMPLE_MAX, 1, 0, 3, 0));
    add_row(FUNC_UNUSED, 12'hABC, 7'h55, 1, mk_out(0, 1, 0, 3, 0));
    add_row(FUNC_READ, 0, 1, 1, mk_out(2048, 1, 0, 3, 0));
    add_row(FUNC_REARM, 12'h555, 7'h2A, 1, mk_out(0, 0, 0, 0, 0));
    add_row(FUNC_READ, 0, 0, 1, mk_out(0, 0, 0, 0, 0));                // store kept
    add_row(FUNC_SAMPLE, 2048, 0, 0, '0);
    add_row(FUNC_SAMPLE, SAMPLE_MAX, 0, 0, '0);
    add_row(FUNC_READ, 0, 1, 0, '0);
    add_row(FUNC_SAMPLE, 12'h0F0, 0, 0, '0);
    add_row(FUNC_READ, 0, 2, 0, '0);
    add_row(FUNC_REARM, 0, 127, 1, mk_out(0, 0, 0, 0, 0));
    foreach (dir_rows[i])
      push_item(dir_rows[i].func, dir_rows[i].smp, dir_rows[i].idx, dir_rows[i].typed,
                dir_rows[i].want);
    drain();

    thr_set = '{0, SAMPLE_MAX, 100, 1500, 3500, 2048, 0, 0, 0, 0};
    len_set = '{1, 128, 0, 255, 4, 200, 2, 37, 0, 0};
    for (int p = 6; p < N_PHASES; p++) thr_set[p] = $urandom_range(0, SAMPLE_MAX);
    for (int p = 8; p < N_PHASES; p++) len_set[p] = $urandom_range(0, 255);

    for (int p = 0; p < N_PHASES; p++) begin
      set_capture(THRESH_W'(thr_set[p]), PRE_LEN_W'(len_set[p]));
      sender_calm = ($urandom_range(0, 3) == 0);
      if (p == 1 || p == 5) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        next_item(f, smp, idx);
        push_item(f, smp, idx, 1'b0, '0);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d items with %0d reads, %0d triggers and %0d captures run to done",
             n_items, n_reads, n_trig, n_done);
    $display("thresholds 0..4095, ring lengths 0..255 incl. out of range, %0d mismatches",
             n_errors);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_store.sv
hw/rtl/pretrigger_threshold_capture.sv
bench/pretrigger_threshold_capture_tb.sv
